[rtl/bdq_pkg.sv]
// shared types and constants of the bounded deque
package bdq_pkg;

  localparam int FUNC_W   = 3;
  localparam int DATA_W   = 32;
  localparam int INDEX_W  = 4;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_POP_FRONT  = 3'd1,
    FUNC_PUSH_BACK  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_READ_INDEX = 3'd4,
    FUNC_CLEAR      = 3'd5
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // result fields that do not come from the store
  typedef struct packed {
    logic                 found;
    logic [COUNT_W-1:0]   count;
    status_e              status;
  } meta_t;

endpackage

[rtl/bdq_if.sv]
// request and response channel interfaces of the bounded deque
interface bdq_req_if;
  logic                         valid;
  logic                         ready;
  logic [bdq_pkg::FUNC_W-1:0]   func;
  logic [bdq_pkg::DATA_W-1:0]   data_in;
  logic [bdq_pkg::INDEX_W-1:0]  index;

  modport source (output valid, func, data_in, index, input ready);
  modport sink   (input valid, func, data_in, index, output ready);
endinterface

interface bdq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bdq_pkg::DATA_W-1:0]   data_out;
  logic                         found;
  logic [bdq_pkg::COUNT_W-1:0]  count;
  logic [bdq_pkg::STATUS_W-1:0] status;

  modport source (output valid, data_out, found, count, status, input ready);
  modport sink   (input valid, data_out, found, count, status, output ready);
endinterface

[rtl/bounded_deque_with_indexed_read.sv]
// bounded double-ended queue with indexed read: top level
// usage: each request on req_i carries func (push front, pop front, push
// back, pop back, read index, clear), a data word and an index. every
// request gives exactly one response on rsp_o with the popped or read word,
// a found flag, the entry count after the operation and a status code.
// entries live in a single-port ram of DEPTH words addressed as a ring from
// a head pointer, with the entry count kept beside it.
// path: the ram is read or written at the edge that takes the request, the
// read word is held in the ram's read register, and the output register
// loads from it when the ram stage advances, which raises rsp_o.valid.
// throughput: one request per cycle while rsp_o.ready stays high, set by
// the single ram port that each request uses at most once.
// stalls: while rsp_o.ready is low the output register holds its response,
// one more request may sit in the ram stage, and req_i.ready then drops.
// reset: head pointer and count go to zero, no response is pending; the
// ram contents are not cleared, and no operation reads an entry that was
// never written.
module bounded_deque_with_indexed_read #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  bdq_req_if.sink    req_i,
  bdq_rsp_if.source  rsp_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int MW = (DATA_WIDTH < bdq_pkg::DATA_W) ? DATA_WIDTH : bdq_pkg::DATA_W;

  logic                       accept;
  logic                       advance;
  logic                       mem_we, mem_re;
  logic [AW-1:0]              mem_addr;
  logic [MW-1:0]              mem_rdata;
  logic [bdq_pkg::DATA_W-1:0] rdata_ext;
  bdq_pkg::meta_t             meta;

  logic                       p_valid_q;
  bdq_pkg::meta_t             p_meta_q;
  logic                       out_valid_q;
  logic [bdq_pkg::DATA_W-1:0] out_data_q;
  bdq_pkg::meta_t             out_meta_q;

  // ram stage moves on when the output register is free or being emptied
  assign advance     = p_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !p_valid_q || advance;
  assign accept      = req_i.valid && req_i.ready;

  bdq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .func_i     (req_i.func),
    .index_i    (req_i.index),
    .mem_we_o   (mem_we),
    .mem_re_o   (mem_re),
    .mem_addr_o (mem_addr),
    .meta_o     (meta)
  );

  bdq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (MW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (req_i.data_in[MW-1:0]),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    rdata_ext         = '0;
    rdata_ext[MW-1:0] = mem_rdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        p_valid_q <= 1'b1;
      end else if (advance) begin
        p_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_meta_q <= meta;
    end
    if (advance) begin
      out_meta_q <= p_meta_q;
      out_data_q <= p_meta_q.found ? rdata_ext : '0;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.data_out = out_data_q;
  assign rsp_o.found    = out_meta_q.found;
  assign rsp_o.count    = out_meta_q.count;
  assign rsp_o.status   = out_meta_q.status;

endmodule

[rtl/bdq_ram.sv]
// single-port synchronous ram holding the deque entries
module bdq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    // read data holds while no read is issued
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bdq_ctrl.sv]
// head pointer and entry count, ram access and status of each request
module bdq_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [bdq_pkg::FUNC_W-1:0]       func_i,
  input  logic [bdq_pkg::INDEX_W-1:0]      index_i,
  output logic                             mem_we_o,
  output logic                             mem_re_o,
  output logic [$clog2(DEPTH)-1:0]         mem_addr_o,
  output bdq_pkg::meta_t                   meta_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > bdq_pkg::INDEX_W) ? CW : bdq_pkg::INDEX_W;

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          full, empty, out_of_range;
  logic [AW-1:0] head_dec;

  // ring position base + off, both below DEPTH
  function automatic logic [AW-1:0] wrap_pos(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign full         = (count_q == CW'(DEPTH));
  assign empty        = (count_q == '0);
  assign out_of_range = (XW'(index_i) >= XW'(count_q));
  assign head_dec     = (head_q == '0) ? AW'(DEPTH - 1) : head_q - AW'(1);

  always_comb begin
    head_d        = head_q;
    count_d       = count_q;
    mem_we_o      = 1'b0;
    mem_re_o      = 1'b0;
    mem_addr_o    = head_q;
    meta_o.found  = 1'b0;
    meta_o.status = bdq_pkg::ST_OK;
    unique case (bdq_pkg::func_e'(func_i))
      bdq_pkg::FUNC_PUSH_FRONT: begin
        if (full) begin
          meta_o.status = bdq_pkg::ST_FULL;
        end else begin
          head_d     = head_dec;
          count_d    = count_q + CW'(1);
          mem_we_o   = accept_i;
          mem_addr_o = head_dec;
        end
      end
      bdq_pkg::FUNC_POP_FRONT: begin
        if (empty) begin
          meta_o.status = bdq_pkg::ST_EMPTY;
        end else begin
          head_d       = wrap_pos(head_q, CW'(1));
          count_d      = count_q - CW'(1);
          mem_re_o     = accept_i;
          mem_addr_o   = head_q;
          meta_o.found = 1'b1;
        end
      end
      bdq_pkg::FUNC_PUSH_BACK: begin
        if (full) begin
          meta_o.status = bdq_pkg::ST_FULL;
        end else begin
          count_d    = count_q + CW'(1);
          mem_we_o   = accept_i;
          mem_addr_o = wrap_pos(head_q, count_q);
        end
      end
      bdq_pkg::FUNC_POP_BACK: begin
        if (empty) begin
          meta_o.status = bdq_pkg::ST_EMPTY;
        end else begin
          count_d      = count_q - CW'(1);
          mem_re_o     = accept_i;
          mem_addr_o   = wrap_pos(head_q, count_q - CW'(1));
          meta_o.found = 1'b1;
        end
      end
      bdq_pkg::FUNC_READ_INDEX: begin
        if (empty) begin
          meta_o.status = bdq_pkg::ST_EMPTY;
        end else if (out_of_range) begin
          meta_o.status = bdq_pkg::ST_RANGE;
        end else begin
          mem_re_o     = accept_i;
          mem_addr_o   = wrap_pos(head_q, CW'(index_i));
          meta_o.found = 1'b1;
        end
      end
      bdq_pkg::FUNC_CLEAR: begin
        head_d  = '0;
        count_d = '0;
      end
      default: begin
        // unused codes leave the state alone
      end
    endcase
    meta_o.count = bdq_pkg::COUNT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

endmodule
